/* design/pkfs_pkg.sv */
// Package for the pose keyframe selector: widths, shared types and the arctangent table.
// Used by the channel interfaces, the CORDIC unit and the top level.
package pkfs_pkg;

  localparam int PosW         = 32;
  localparam int RotW         = 16;
  localparam int DistLimW     = 48;
  localparam int AngLimW      = 15;
  localparam int CfgDataW     = 48;
  localparam int CfgIdxW      = 1;

  localparam int CordicSteps  = 16;
  localparam int CordicW      = 20;
  localparam int ZW           = 24;
  localparam int RndSh        = 7;
  localparam int AngW         = ZW - RndSh;
  localparam int AtanW        = 20;
  localparam int AtanIdxW     = 5;

  localparam logic signed [ZW-1:0] PiFine   = 24'sd3294199;
  localparam int                   PiAng    = 25736;
  localparam int                   TwoPiAng = 51472;

  localparam logic [CfgIdxW-1:0] CfgDistSqLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAngleLimit  = 1'd1;

  typedef struct packed {
    logic signed [RotW-1:0] rot_00;
    logic signed [RotW-1:0] rot_10;
    logic signed [RotW-1:0] rot_11;
    logic signed [RotW-1:0] rot_21;
    logic signed [RotW-1:0] rot_02;
    logic signed [RotW-1:0] rot_22;
  } rot_t;

  typedef struct packed {
    logic signed [AngW-1:0] yaw;
    logic signed [AngW-1:0] roll;
    logic signed [AngW-1:0] pitch;
  } angles_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // arctan(2^-i) in units of 2^-20 rad, rounded to nearest
  function automatic logic [AtanW-1:0] atan_fine(input logic [AtanIdxW-1:0] idx);
    logic [AtanW-1:0] v;
    case (idx)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/pkfs_if.sv */
// Valid/ready channel interfaces of the pose keyframe selector: pose in, keyframe flag out.
// Depends on pkfs_pkg.
interface pkfs_pose_if;
  import pkfs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  logic signed [RotW-1:0] rot_00;
  logic signed [RotW-1:0] rot_10;
  logic signed [RotW-1:0] rot_11;
  logic signed [RotW-1:0] rot_21;
  logic signed [RotW-1:0] rot_02;
  logic signed [RotW-1:0] rot_22;
  modport source (output valid, pos_x, pos_y, pos_z, rot_00, rot_10, rot_11, rot_21, rot_02,
                  rot_22, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, rot_00, rot_10, rot_11, rot_21, rot_02,
                rot_22, output ready);
endinterface

interface pkfs_flag_if;
  logic valid;
  logic ready;
  logic is_keyframe;
  modport source (output valid, is_keyframe, input ready);
  modport sink (input valid, is_keyframe, output ready);
endinterface

/* design/pose_keyframe_selector_core.sv */
// Top level of the pose keyframe selector: control, serial squared distance, decision.
// Depends on pkfs_pkg, pkfs_if and pkfs_cordic.
//
// Usage: a pose transaction enters on pose_i (valid/ready); for each one a single
// transaction with is_keyframe leaves on flag_o. Thresholds are written through
// cfg_we_i / cfg_idx_i / cfg_data_i (index 0 squared distance, index 1 angle) while idle.
// The squared distance is built radix-4, two multiplier bits per cycle, one axis after
// another (magnitude, triple, multiply states). In parallel the CORDIC unit computes the
// three angles in turn. The result is registered once both are done, and pose_i.ready
// rises in the same cycle, so no new pose is taken while one is still in progress.
// The result sits in an output register; a stalled receiver holds the next decision
// back (the reference pose is not updated) until the register is free.
// Reset clears the reference pose, the keyframe-present flag and the output valid flag,
// and loads the threshold defaults; the first pose after reset is always a keyframe.
module pose_keyframe_selector_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pkfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pkfs_pkg::CfgDataW-1:0] cfg_data_i,
  pkfs_pose_if.sink                    pose_i,
  pkfs_flag_if.source                  flag_o
);
  import pkfs_pkg::*;

  localparam int MagW  = PosW;
  localparam int SqW   = 2 * MagW;
  localparam int AccW  = SqW + 2;
  localparam int DigN  = MagW / 2;
  localparam int DigW  = $clog2(DigN);
  localparam int DiffW = AngW + 2;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef enum logic [2:0] {SIdle, SMag, STriple, SMul, SWait, SDone} state_e;

  state_e                   state_q;
  logic [1:0]               axis_q;
  logic [DigW-1:0]          digit_q;
  logic                     ang_ready_q, have_kf_q, out_valid_q, out_flag_q;
  logic [DistLimW-1:0]      dist_lim_q;
  logic [AngLimW-1:0]       ang_lim_q;
  logic signed [PosW-1:0]   ref_x_q, ref_y_q, ref_z_q;
  angles_t                  ref_ang_q;
  logic signed [PosW-1:0]   px_q, py_q, pz_q;
  rot_t                     rot_q;
  logic [MagW-1:0]          mplier_q;
  logic [SqW-1:0]           mcand_q, m3_q;
  logic [AccW-1:0]          acc_q;

  angles_t                  angles;
  cordic_stat_t             cor_stat;
  logic                     accept, out_free, last_digit, kf_flag;
  logic signed [PosW-1:0]   pos_sel, ref_sel;
  logic signed [PosW:0]     diff, mag_w;
  logic [SqW-1:0]           addend;

  function automatic logic angle_exceeds(input logic signed [AngW-1:0] kf_ang,
                                         input logic signed [AngW-1:0] now,
                                         input logic [AngLimW-1:0] lim);
    logic signed [DiffW-1:0] d;
    logic [DiffW-1:0]        mag;
    d = {{2{kf_ang[AngW-1]}}, kf_ang} - {{2{now[AngW-1]}}, now};
    if (d > DiffW'(PiAng)) begin
      d = d - DiffW'(TwoPiAng);
    end else if (d < -DiffW'(PiAng)) begin
      d = d + DiffW'(TwoPiAng);
    end
    mag = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
    return mag > {{(DiffW-AngLimW){1'b0}}, lim};
  endfunction

  pkfs_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .rot_i    (rot_q),
    .angles_o (angles),
    .stat_o   (cor_stat)
  );

  assign pose_i.ready      = (state_q == SIdle);
  assign accept            = pose_i.valid && pose_i.ready;
  assign out_free          = !out_valid_q || flag_o.ready;
  assign last_digit        = (digit_q == DigW'(DigN - 1));
  assign flag_o.valid      = out_valid_q;
  assign flag_o.is_keyframe = out_flag_q;

  always_comb begin
    case (axis_q)
      AxisY: begin
        pos_sel = py_q;
        ref_sel = ref_y_q;
      end
      AxisZ: begin
        pos_sel = pz_q;
        ref_sel = ref_z_q;
      end
      default: begin
        pos_sel = px_q;
        ref_sel = ref_x_q;
      end
    endcase
    diff  = {pos_sel[PosW-1], pos_sel} - {ref_sel[PosW-1], ref_sel};
    mag_w = diff[PosW] ? -diff : diff;
    case (mplier_q[1:0])
      2'd1:    addend = mcand_q;
      2'd2:    addend = {mcand_q[SqW-2:0], 1'b0};
      2'd3:    addend = m3_q;
      default: addend = '0;
    endcase
    kf_flag = !have_kf_q
           || (acc_q > {{(AccW-DistLimW){1'b0}}, dist_lim_q})
           || angle_exceeds(ref_ang_q.yaw, angles.yaw, ang_lim_q)
           || angle_exceeds(ref_ang_q.roll, angles.roll, ang_lim_q)
           || angle_exceeds(ref_ang_q.pitch, angles.pitch, ang_lim_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      axis_q      <= AxisX;
      digit_q     <= '0;
      ang_ready_q <= 1'b0;
      have_kf_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dist_lim_q  <= DistLimW'(41943);
      ang_lim_q   <= AngLimW'(715);
      ref_x_q     <= '0;
      ref_y_q     <= '0;
      ref_z_q     <= '0;
      ref_ang_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDistSqLimit: dist_lim_q <= cfg_data_i[DistLimW-1:0];
          CfgAngleLimit:  ang_lim_q  <= cfg_data_i[AngLimW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        ang_ready_q <= 1'b0;
      end else if (cor_stat.done) begin
        ang_ready_q <= 1'b1;
      end
      if (state_q == SDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (flag_o.valid && flag_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (accept) begin
            state_q     <= SMag;
            axis_q      <= AxisX;
          end
        end
        SMag: begin
          state_q <= STriple;
          digit_q <= '0;
        end
        STriple: state_q <= SMul;
        SMul: begin
          digit_q <= digit_q + DigW'(1);
          if (last_digit) begin
            if (axis_q == AxisZ) begin
              state_q <= SWait;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= SMag;
            end
          end
        end
        SWait: begin
          if (ang_ready_q) begin
            state_q <= SDone;
          end
        end
        SDone: begin
          if (out_free) begin
            state_q     <= SIdle;
            if (kf_flag) begin
              have_kf_q <= 1'b1;
              ref_x_q   <= px_q;
              ref_y_q   <= py_q;
              ref_z_q   <= pz_q;
              ref_ang_q <= angles;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q         <= pose_i.pos_x;
      py_q         <= pose_i.pos_y;
      pz_q         <= pose_i.pos_z;
      rot_q.rot_00 <= pose_i.rot_00;
      rot_q.rot_10 <= pose_i.rot_10;
      rot_q.rot_11 <= pose_i.rot_11;
      rot_q.rot_21 <= pose_i.rot_21;
      rot_q.rot_02 <= pose_i.rot_02;
      rot_q.rot_22 <= pose_i.rot_22;
      acc_q        <= '0;
    end
    if (state_q == SMag) begin
      mplier_q <= mag_w[MagW-1:0];
      mcand_q  <= {{(SqW-MagW){1'b0}}, mag_w[MagW-1:0]};
    end
    if (state_q == STriple) begin
      m3_q <= mcand_q + {mcand_q[SqW-2:0], 1'b0};
    end
    if (state_q == SMul) begin
      acc_q    <= acc_q + {2'b00, addend};
      mplier_q <= {2'b00, mplier_q[MagW-1:2]};
      mcand_q  <= {mcand_q[SqW-3:0], 2'b00};
      m3_q     <= {m3_q[SqW-3:0], 2'b00};
    end
    if (state_q == SDone && out_free) begin
      out_flag_q <= kf_flag;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !cor_stat.busy)
    else $error("angle unit busy while waiting for a pose");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMul && last_digit) |=> (mplier_q == '0))
    else $error("multiplier digits left over after the last step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone && out_free && !have_kf_q) |=> (out_valid_q && out_flag_q && have_kf_q))
    else $error("first pose not taken as keyframe");

endmodule

/* design/pkfs_cordic.sv */
// Shared iterative CORDIC: yaw, roll and pitch by atan2, one micro-rotation per cycle.
// Depends on pkfs_pkg.
module pkfs_cordic (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  pkfs_pkg::rot_t         rot_i,
  output pkfs_pkg::angles_t      angles_o,
  output pkfs_pkg::cordic_stat_t stat_o
);
  import pkfs_pkg::*;

  localparam int StepW = $clog2(CordicSteps);

  typedef enum logic [1:0] {SelYaw, SelRoll, SelPitch} sel_e;

  sel_e                    sel_q;
  logic                    busy_q, iter_q, done_q, zero_q;
  logic [StepW-1:0]        step_q;
  logic signed [CordicW-1:0] x_q, y_q;
  logic signed [ZW-1:0]    z_q;
  angles_t                 angles_q;

  logic signed [RotW-1:0]    vx, vy;
  logic signed [CordicW-1:0] vx_e, vy_e, xs, ys, x_nx, y_nx;
  logic signed [ZW-1:0]      atan_e, z_nx, z_rnd;
  logic signed [AngW-1:0]    ang_nx;
  logic                      last_step;

  always_comb begin
    case (sel_q)
      SelYaw: begin
        vy = rot_i.rot_10;
        vx = rot_i.rot_00;
      end
      SelRoll: begin
        vy = rot_i.rot_21;
        vx = rot_i.rot_11;
      end
      SelPitch: begin
        vy = rot_i.rot_02;
        vx = rot_i.rot_22;
      end
      default: begin
        vy = rot_i.rot_10;
        vx = rot_i.rot_00;
      end
    endcase
    vx_e   = {{(CordicW-RotW){vx[RotW-1]}}, vx};
    vy_e   = {{(CordicW-RotW){vy[RotW-1]}}, vy};
    xs     = x_q >>> step_q;
    ys     = y_q >>> step_q;
    atan_e = {{(ZW-AtanW){1'b0}}, atan_fine(AtanIdxW'(step_q))};
    if (!y_q[CordicW-1]) begin
      x_nx = x_q + ys;
      y_nx = y_q - xs;
      z_nx = z_q + atan_e;
    end else begin
      x_nx = x_q - ys;
      y_nx = y_q + xs;
      z_nx = z_q - atan_e;
    end
    z_rnd     = z_nx + ZW'(64);
    ang_nx    = zero_q ? '0 : z_rnd[ZW-1:RndSh];
    last_step = (step_q == StepW'(CordicSteps - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= 1'b0;
      done_q <= 1'b0;
      sel_q  <= SelYaw;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= 1'b0;
        sel_q  <= SelYaw;
      end else if (busy_q) begin
        if (!iter_q) begin
          iter_q <= 1'b1;
          step_q <= '0;
        end else begin
          step_q <= step_q + StepW'(1);
          if (last_step) begin
            iter_q <= 1'b0;
            case (sel_q)
              SelYaw:   sel_q <= SelRoll;
              SelRoll:  sel_q <= SelPitch;
              default: begin
                busy_q <= 1'b0;
                done_q <= 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !iter_q) begin
      zero_q <= (vx == '0) && (vy == '0);
      if (vx[RotW-1]) begin
        x_q <= -vx_e;
        y_q <= -vy_e;
        z_q <= vy[RotW-1] ? -PiFine : PiFine;
      end else begin
        x_q <= vx_e;
        y_q <= vy_e;
        z_q <= '0;
      end
    end else if (busy_q && iter_q) begin
      x_q <= x_nx;
      y_q <= y_nx;
      z_q <= z_nx;
      if (last_step) begin
        case (sel_q)
          SelYaw:   angles_q.yaw   <= ang_nx;
          SelRoll:  angles_q.roll  <= ang_nx;
          default:  angles_q.pitch <= ang_nx;
        endcase
      end
    end
  end

  assign angles_o    = angles_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
